/* rtl/brw_pkg.sv */
// Shared types and constants for the big-endian RAM window.
// No dependencies; the top level and brw_window import this package.
`default_nettype none

package brw_pkg;

   localparam int NUM_LANES = 4;

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_SIZE   = 1'b1;

   localparam logic [31:0] ONES_BYTE = 32'h0000_00FF;
   localparam logic [31:0] ONES_HALF = 32'h0000_FFFF;
   localparam logic [31:0] ONES_WORD = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_FINISH
   } state_type;

   // Result of the window decode, handed from the decoder to the sequencer.
   typedef struct packed {
      logic        hit;
      logic [23:0] offset;
   } lookup_type;

endpackage

`default_nettype wire

/* rtl/bounded_ram_window_big_endian.sv */
// Big-endian RAM window: one word in, one word out, stored in four byte-lane banks.
// An accepted word is registered; the issue state drives the single-port bank access,
// and the finish state registers the response from the registered read data once the
// response register is free; the next word is taken only after that.
// Reset is synchronous: it clears control registers, then zeroes all rows before any word.
// Depends on brw_pkg, brw_ram and brw_window.
`default_nettype none

module bounded_ram_window_big_endian
   import brw_pkg::*;
#(
   parameter int CAPACITY_BYTES = 524288,
   parameter int BASE_ADDRESS   = 12582912
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [71:0] req_tdata,   // bus_address[31:0], access_size[34:32],
                                         // write_data[66:35], zero pad[71:67]
   input  wire logic        req_tuser,   // mode (0 read, 1 write)
   // Response channel.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // read_data[31:0]
   output      logic        rsp_tuser,   // hit
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [19:0] csr_wdata
);

   // Each lane holds the bytes whose store offset has that value modulo four.
   localparam int ROWS  = (CAPACITY_BYTES + NUM_LANES - 1) / NUM_LANES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Configuration registers.
   logic        enable_ff, enable_in;
   logic [19:0] size_ff, size_in;

   // Sequencer state and clearing counter.
   state_type   state_ff, state_in;
   logic [ROW_W-1:0] clr_ff, clr_in;

   // Captured request.
   logic        mode_ff, mode_in;
   logic [31:0] addr_ff, addr_in;
   logic [2:0]  asize_ff, asize_in;
   logic [31:0] wdata_ff, wdata_in;

   // Lookup result carried from the issue cycle to the finish cycle.
   logic        hit_ff, hit_in;
   logic [1:0]  lo_ff, lo_in;

   // Response register.
   logic        rvalid_ff, rvalid_in;
   logic        rhit_ff, rhit_in;
   logic [31:0] rdata_ff, rdata_in;

   // FSM outputs.
   logic        accept;
   logic        clearing;
   logic        issuing;
   logic        finishing;
   logic        out_free;

   lookup_type  lookup;

   logic [ROW_W-1:0] lane_addr  [NUM_LANES];
   logic             lane_we    [NUM_LANES];
   logic [7:0]       lane_wdata [NUM_LANES];
   logic [7:0]       lane_rdata [NUM_LANES];

   logic        clr_done;
   logic [31:0] assembled;

   brw_window #(
      .CAPACITY_BYTES (CAPACITY_BYTES),
      .BASE_ADDRESS   (BASE_ADDRESS)
   ) u_window (
      .region_enabled (enable_ff),
      .region_size    (size_ff),
      .bus_address    (addr_ff),
      .access_size    (asize_ff),
      .lookup         (lookup)
   );

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      brw_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_bank (
         .clock (clock),
         .we    (lane_we[g]),
         .addr  (lane_addr[g]),
         .wdata (lane_wdata[g]),
         .rdata (lane_rdata[g])
      );
   end

   assign clr_done = (clr_ff == ROW_W'(ROWS - 1));
   assign out_free = !rvalid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_ISSUE;
         ST_ISSUE:  state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // FSM outputs.
   always_comb begin
      req_tready = 1'b0;
      clearing   = 1'b0;
      issuing    = 1'b0;
      finishing  = 1'b0;
      case (state_ff)
         ST_CLEAR:  clearing   = 1'b1;
         ST_IDLE:   req_tready = 1'b1;
         ST_ISSUE:  issuing    = 1'b1;
         ST_FINISH: finishing  = out_free;
         default:   clearing   = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Bank access. In the issue cycle a lane takes part when its byte index,
   // counted from the access offset, falls inside the access size. The lanes
   // below the offset's low bits hold bytes of the next row.
   always_comb begin
      logic [1:0] idx;
      logic [1:0] sh;
      logic [23:0] row;
      for (int l = 0; l < NUM_LANES; l++) begin
         idx = 2'(l) - lookup.offset[1:0];
         sh  = 2'(asize_ff - 3'd1) - idx;
         row = (lookup.offset >> 2) + ((2'(l) < lookup.offset[1:0]) ? 24'd1 : 24'd0);
         if (clearing) begin
            lane_addr[l]  = clr_ff;
            lane_we[l]    = 1'b1;
            lane_wdata[l] = 8'd0;
         end else begin
            lane_addr[l]  = row[ROW_W-1:0];
            lane_we[l]    = issuing && lookup.hit && (mode_ff == MODE_WRITE) &&
                            ({1'b0, idx} < asize_ff);
            lane_wdata[l] = 8'(wdata_ff >> {sh, 3'b000});
         end
      end
   end

   // Read data assembly: byte index zero is the most significant byte.
   always_comb begin
      logic [1:0] idx;
      logic [1:0] sh;
      assembled = 32'd0;
      for (int l = 0; l < NUM_LANES; l++) begin
         idx = 2'(l) - lo_ff;
         sh  = 2'(asize_ff - 3'd1) - idx;
         if ({1'b0, idx} < asize_ff) begin
            assembled = assembled | (32'(lane_rdata[l]) << {sh, 3'b000});
         end
      end
   end

   // Register next values.
   always_comb begin
      enable_in = enable_ff;
      size_in   = size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            CSR_SIZE:   size_in   = csr_wdata;
            default:    enable_in = enable_ff;
         endcase
      end

      clr_in = clearing ? (clr_ff + ROW_W'(1)) : clr_ff;

      mode_in  = accept ? req_tuser          : mode_ff;
      addr_in  = accept ? req_tdata[31:0]    : addr_ff;
      asize_in = accept ? req_tdata[34:32]   : asize_ff;
      wdata_in = accept ? req_tdata[66:35]   : wdata_ff;

      hit_in = issuing ? lookup.hit          : hit_ff;
      lo_in  = issuing ? lookup.offset[1:0]  : lo_ff;

      rvalid_in = finishing ? 1'b1 : (rsp_tready ? 1'b0 : rvalid_ff);
      rhit_in   = finishing ? hit_ff : rhit_ff;
      rdata_in  = rdata_ff;
      if (finishing) begin
         if (mode_ff == MODE_WRITE) begin
            rdata_in = 32'd0;
         end else if (hit_ff) begin
            rdata_in = assembled;
         end else if (asize_ff == SIZE_BYTE) begin
            rdata_in = ONES_BYTE;
         end else if (asize_ff == SIZE_HALF) begin
            rdata_in = ONES_HALF;
         end else begin
            rdata_in = ONES_WORD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         size_ff   <= 20'd0;
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         size_ff   <= size_in;
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      addr_ff  <= addr_in;
      asize_ff <= asize_in;
      wdata_ff <= wdata_in;
      hit_ff   <= hit_in;
      lo_ff    <= lo_in;
      rhit_ff  <= rhit_in;
      rdata_ff <= rdata_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = rhit_ff;

   // An accepted word always moves on to the bank access in the next cycle.
   a_accept_issue: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ISSUE))
      else $error("accepted word did not reach the issue cycle");

   // A write that misses the window never touches a bank.
   a_miss_no_write: assert property (@(posedge clock) disable iff (reset)
      (issuing && !lookup.hit) |->
         !(lane_we[0] || lane_we[1] || lane_we[2] || lane_we[3]))
      else $error("bank written on a window miss");

   // A hit is only reported for a valid access size.
   a_hit_size: assert property (@(posedge clock) disable iff (reset)
      (issuing && lookup.hit) |->
         (asize_ff == SIZE_BYTE || asize_ff == SIZE_HALF || asize_ff == SIZE_WORD))
      else $error("hit reported for an invalid access size");

endmodule

`default_nettype wire

/* rtl/brw_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module brw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                        wdata,
   output      logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

/* rtl/brw_window.sv */
// Window decode: hit test and store offset for one access.
// Depends on brw_pkg.
`default_nettype none

module brw_window
   import brw_pkg::*;
#(
   parameter int CAPACITY_BYTES = 524288,
   parameter int BASE_ADDRESS   = 12582912
) (
   input  wire logic        region_enabled,
   input  wire logic [19:0] region_size,
   input  wire logic [31:0] bus_address,
   input  wire logic [2:0]  access_size,
   output      lookup_type  lookup
);

   localparam logic [25:0] BASE_W = 26'(BASE_ADDRESS);
   localparam logic [25:0] CAP_W  = 26'(CAPACITY_BYTES);

   logic [25:0] raw;
   logic [25:0] limit;
   logic [25:0] rel;
   logic [25:0] last_end;
   logic        size_ok;

   always_comb begin
      raw      = {2'b00, bus_address[23:0]};
      limit    = ({6'd0, region_size} > CAP_W) ? CAP_W : {6'd0, region_size};
      rel      = raw - BASE_W;
      last_end = rel + {23'd0, access_size};
      size_ok  = (access_size == SIZE_BYTE) || (access_size == SIZE_HALF) ||
                 (access_size == SIZE_WORD);
      lookup.hit    = region_enabled && (limit != 26'd0) && size_ok &&
                      (raw >= BASE_W) && (last_end <= limit);
      lookup.offset = rel[23:0];
   end

endmodule

`default_nettype wire
